@@ hw/rtl/eqc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eqc_pkg
// Shared types, fixed-point constants and rounding helpers for the
// Euler-angle / quaternion converter.
// ----------------------------------------------------------------------------
package eqc_pkg;

   typedef enum logic {
      CMD_E2Q = 1'b0,
      CMD_Q2E = 1'b1
   } cmd_type;

   // fraction bits of the formats at the edges of the datapath
   localparam int Q_HALF  = 13;
   localparam int Q_PROD  = 28;
   localparam int Q_QUAT  = 14;
   localparam int Q_ANGLE = 12;
   localparam int Q_TAB   = 30;

   localparam int ATAN_TAB_LEN = 24;

   localparam logic signed [63:0] PI_Q30   = 64'sd3373259426;
   localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;

   localparam logic signed [63:0] ATAN_Q30 [ATAN_TAB_LEN] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
      64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
      64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
      64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
      64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
      64'sd1024,      64'sd512,       64'sd256,       64'sd128
   };

   // add half an lsb, then floor
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int s);
      logic signed [63:0] half;
      half = (s == 0) ? 64'sd0 : (64'sd1 <<< (s - 1));
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [63:0] resc(input logic signed [63:0] v,
                                               input int from_q, input int to_q);
      if (to_q >= from_q) begin
         return v <<< (to_q - from_q);
      end
      return rnd_shr(v, from_q - to_q);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end
      if (v < -64'sd32768) begin
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/euler_quaternion_converter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// euler_quaternion_converter_top
// Pipelined Euler-angle <-> quaternion converter built on shared CORDIC lanes.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the pipeline is held, and returns one beat
// per input beat, in order. The pipeline has three front stages (products,
// sums, square of the asin argument), FRAC_BITS + 2 stages for the
// one-digit-per-stage square root, CORDIC_STEPS + 1 stages of three parallel
// CORDIC lanes, and three back stages for the quaternion products and output
// register. The whole pipeline holds while a result sits in the output
// register and rsp_ready is low.
module euler_quaternion_converter_top
   import eqc_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic signed [15:0] req_angle_x,
   input  wire logic signed [15:0] req_angle_y,
   input  wire logic signed [15:0] req_angle_z,
   input  wire logic signed [15:0] req_quat_x_in,
   input  wire logic signed [15:0] req_quat_y_in,
   input  wire logic signed [15:0] req_quat_z_in,
   input  wire logic signed [15:0] req_quat_w_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_quat_x_out,
   output logic signed [15:0]      rsp_quat_y_out,
   output logic signed [15:0]      rsp_quat_z_out,
   output logic signed [15:0]      rsp_quat_w_out,
   output logic signed [15:0]      rsp_pitch_out,
   output logic signed [15:0]      rsp_yaw_out,
   output logic signed [15:0]      rsp_roll_out
);

   localparam int W     = FRAC_BITS + 8;
   localparam int ZW    = FRAC_BITS + 4;
   localparam int VW    = FRAC_BITS + 2;
   localparam int SW    = FRAC_BITS + 2;
   localparam int RW    = 2 * FRAC_BITS + 1;
   localparam int VVW   = 2 * VW;
   localparam int DEPTH = FRAC_BITS + CORDIC_STEPS + 9;

   localparam logic signed [ZW-1:0] PI_F   = ZW'(rnd_shr(PI_Q30, Q_TAB - FRAC_BITS));
   localparam logic signed [ZW-1:0] HPI_F  = ZW'(rnd_shr(PI_Q30 / 2, Q_TAB - FRAC_BITS));
   localparam logic signed [W-1:0]  GAIN_F = W'(rnd_shr(GAIN_Q30, Q_TAB - FRAC_BITS));
   localparam logic signed [VVW-1:0] ONE2  = VVW'(1) <<< (2 * FRAC_BITS);
   localparam logic signed [35:0]   V_LIM  = 36'sd268435456;

   typedef struct packed {
      cmd_type                cmd;
      logic [2:0]             flip;
      logic signed [ZW-1:0]   z0;
      logic signed [ZW-1:0]   z1;
      logic signed [ZW-1:0]   z2;
      logic signed [W-1:0]    py;
      logic signed [W-1:0]    px;
      logic signed [W-1:0]    ry;
      logic signed [W-1:0]    rx;
      logic signed [VW-1:0]   v;
   } carry_type;

   typedef struct packed {
      logic signed [W-1:0]  x;
      logic signed [W-1:0]  y;
      logic signed [ZW-1:0] z;
   } lane_type;

   typedef struct packed {
      cmd_type        cmd;
      logic [2:0]     flip;
      lane_type [2:0] ln;
   } cstage_type;

   function automatic logic signed [SW-1:0] mulf(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
      logic signed [2*SW-1:0] p;
      p = (2*SW)'(a) * (2*SW)'(b);
      return SW'(rnd_shr(64'(p), FRAC_BITS));
   endfunction

   // left half plane folds to the right with an offset of pi
   function automatic lane_type vec_init(input logic signed [W-1:0] yv,
                                         input logic signed [W-1:0] xv);
      lane_type r;
      if (xv < 0) begin
         r.x = -xv;
         r.y = -yv;
         r.z = (yv >= 0) ? PI_F : -PI_F;
      end else begin
         r.x = xv;
         r.y = yv;
         r.z = '0;
      end
      return r;
   endfunction

   logic             pipe_adv;
   logic [DEPTH-1:0] vld_ff;

   assign pipe_adv  = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = pipe_adv;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // stage a: half angles with range fold, quaternion products
   logic signed [15:0]   ang [3];
   logic signed [ZW-1:0] a_half [3];
   logic signed [ZW-1:0] a_z_in [3];
   logic signed [ZW-1:0] a_z_ff [3];
   logic [2:0]           a_flip_in, a_flip_ff;
   cmd_type              a_cmd_ff;
   logic signed [31:0]   a_xx_ff, a_yy_ff, a_zz_ff, a_ww_ff, a_yz_ff;
   logic signed [31:0]   a_wx_ff, a_xz_ff, a_wy_ff, a_xy_ff, a_wz_ff;

   assign ang[0] = req_angle_x;
   assign ang[1] = req_angle_y;
   assign ang[2] = req_angle_z;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         a_half[l] = ZW'(resc(64'(ang[l]), Q_HALF, FRAC_BITS));
         if (a_half[l] > HPI_F) begin
            a_z_in[l]    = a_half[l] - PI_F;
            a_flip_in[l] = 1'b1;
         end else if (a_half[l] < -HPI_F) begin
            a_z_in[l]    = a_half[l] + PI_F;
            a_flip_in[l] = 1'b1;
         end else begin
            a_z_in[l]    = a_half[l];
            a_flip_in[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         a_cmd_ff  <= cmd_type'(req_command);
         a_flip_ff <= a_flip_in;
         a_z_ff    <= a_z_in;
         a_xx_ff   <= 32'(req_quat_x_in) * 32'(req_quat_x_in);
         a_yy_ff   <= 32'(req_quat_y_in) * 32'(req_quat_y_in);
         a_zz_ff   <= 32'(req_quat_z_in) * 32'(req_quat_z_in);
         a_ww_ff   <= 32'(req_quat_w_in) * 32'(req_quat_w_in);
         a_yz_ff   <= 32'(req_quat_y_in) * 32'(req_quat_z_in);
         a_wx_ff   <= 32'(req_quat_w_in) * 32'(req_quat_x_in);
         a_xz_ff   <= 32'(req_quat_x_in) * 32'(req_quat_z_in);
         a_wy_ff   <= 32'(req_quat_w_in) * 32'(req_quat_y_in);
         a_xy_ff   <= 32'(req_quat_x_in) * 32'(req_quat_y_in);
         a_wz_ff   <= 32'(req_quat_w_in) * 32'(req_quat_z_in);
      end
   end

   // stage b: atan2 operands and clamped asin argument
   logic signed [35:0] b_pn, b_pd, b_rn, b_rd, b_vr, b_vc;
   carry_type          b_in, b_ff;

   always_comb begin
      b_pn = (36'(a_yz_ff) + 36'(a_wx_ff)) <<< 1;
      b_pd = 36'(a_ww_ff) - 36'(a_xx_ff) - 36'(a_yy_ff) + 36'(a_zz_ff);
      b_rn = (36'(a_xy_ff) + 36'(a_wz_ff)) <<< 1;
      b_rd = 36'(a_ww_ff) + 36'(a_xx_ff) - 36'(a_yy_ff) - 36'(a_zz_ff);
      b_vr = -((36'(a_xz_ff) - 36'(a_wy_ff)) <<< 1);
      if (b_vr > V_LIM) begin
         b_vc = V_LIM;
      end else if (b_vr < -V_LIM) begin
         b_vc = -V_LIM;
      end else begin
         b_vc = b_vr;
      end
      b_in.cmd  = a_cmd_ff;
      b_in.flip = a_flip_ff;
      b_in.z0   = a_z_ff[0];
      b_in.z1   = a_z_ff[1];
      b_in.z2   = a_z_ff[2];
      b_in.py   = W'(resc(64'(b_pn), Q_PROD, FRAC_BITS));
      b_in.px   = W'(resc(64'(b_pd), Q_PROD, FRAC_BITS));
      b_in.ry   = W'(resc(64'(b_rn), Q_PROD, FRAC_BITS));
      b_in.rx   = W'(resc(64'(b_rd), Q_PROD, FRAC_BITS));
      b_in.v    = VW'(resc(64'(b_vc), Q_PROD, FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         b_ff <= b_in;
      end
   end

   // stage c: square of the asin argument
   carry_type           c_car_ff;
   logic signed [VVW-1:0] c_vv_in, c_vv_ff;

   assign c_vv_in = VVW'(b_ff.v) * VVW'(b_ff.v);

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         c_car_ff <= b_ff;
         c_vv_ff  <= c_vv_in;
      end
   end

   // square root of 1 - v*v, one result bit per stage
   carry_type      sq_car_ff  [FRAC_BITS+2];
   logic [RW-1:0]  sq_rem_ff  [FRAC_BITS+2];
   logic [RW-1:0]  sq_root_ff [FRAC_BITS+2];

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         sq_car_ff[0]  <= c_car_ff;
         sq_rem_ff[0]  <= (c_vv_ff >= ONE2) ? '0 : RW'(ONE2 - c_vv_ff);
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_sqrt
      localparam logic [RW-1:0] BIT_K = RW'(1) << (2 * (FRAC_BITS - k));
      logic [RW:0] trial;

      assign trial = {1'b0, sq_root_ff[k]} + {1'b0, BIT_K};

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            sq_car_ff[k+1] <= sq_car_ff[k];
            if ({1'b0, sq_rem_ff[k]} >= trial) begin
               sq_rem_ff[k+1]  <= sq_rem_ff[k] - trial[RW-1:0];
               sq_root_ff[k+1] <= (sq_root_ff[k] >> 1) + BIT_K;
            end else begin
               sq_rem_ff[k+1]  <= sq_rem_ff[k];
               sq_root_ff[k+1] <= sq_root_ff[k] >> 1;
            end
         end
      end
   end

   // cordic entry: rotation lanes for sin/cos, vectoring lanes for atan2
   cstage_type cs_ff [CORDIC_STEPS+1];
   cstage_type e_in;
   carry_type  e_car;

   always_comb begin
      e_car   = sq_car_ff[FRAC_BITS+1];
      e_in.cmd  = e_car.cmd;
      e_in.flip = e_car.flip;
      if (e_car.cmd == CMD_Q2E) begin
         e_in.ln[0] = vec_init(e_car.py, e_car.px);
         e_in.ln[1] = vec_init(W'(e_car.v), W'(sq_root_ff[FRAC_BITS+1]));
         e_in.ln[2] = vec_init(e_car.ry, e_car.rx);
      end else begin
         e_in.ln[0] = lane_type'{x: GAIN_F, y: '0, z: e_car.z0};
         e_in.ln[1] = lane_type'{x: GAIN_F, y: '0, z: e_car.z1};
         e_in.ln[2] = lane_type'{x: GAIN_F, y: '0, z: e_car.z2};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         cs_ff[0] <= e_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [ZW-1:0] ATAN_I =
         ZW'(rnd_shr(ATAN_Q30[i], Q_TAB - FRAC_BITS));
      cstage_type cs_in;

      always_comb begin
         cs_in = cs_ff[i];
         for (int l = 0; l < 3; l++) begin
            if ((cs_ff[i].cmd == CMD_Q2E) ? (cs_ff[i].ln[l].y < 0)
                                          : (cs_ff[i].ln[l].z >= 0)) begin
               cs_in.ln[l].x = cs_ff[i].ln[l].x - (cs_ff[i].ln[l].y >>> i);
               cs_in.ln[l].y = cs_ff[i].ln[l].y + (cs_ff[i].ln[l].x >>> i);
               cs_in.ln[l].z = cs_ff[i].ln[l].z - ATAN_I;
            end else begin
               cs_in.ln[l].x = cs_ff[i].ln[l].x + (cs_ff[i].ln[l].y >>> i);
               cs_in.ln[l].y = cs_ff[i].ln[l].y - (cs_ff[i].ln[l].x >>> i);
               cs_in.ln[l].z = cs_ff[i].ln[l].z + ATAN_I;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            cs_ff[i+1] <= cs_in;
         end
      end
   end

   // back stage 1: sin/cos pair products, angle outputs
   cstage_type           p1_src;
   logic signed [SW-1:0] p1_s [3];
   logic signed [SW-1:0] p1_c [3];
   cmd_type              p1_cmd_ff;
   logic signed [SW-1:0] p1_sxcy_ff, p1_cxsy_ff, p1_cxcy_ff, p1_sxsy_ff;
   logic signed [SW-1:0] p1_sz_ff, p1_cz_ff;
   logic signed [15:0]   p1_pitch_ff, p1_yaw_ff, p1_roll_ff;

   always_comb begin
      p1_src = cs_ff[CORDIC_STEPS];
      for (int l = 0; l < 3; l++) begin
         p1_s[l] = p1_src.flip[l] ? -SW'(p1_src.ln[l].y) : SW'(p1_src.ln[l].y);
         p1_c[l] = p1_src.flip[l] ? -SW'(p1_src.ln[l].x) : SW'(p1_src.ln[l].x);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         p1_cmd_ff   <= p1_src.cmd;
         p1_sxcy_ff  <= mulf(p1_s[0], p1_c[1]);
         p1_cxsy_ff  <= mulf(p1_c[0], p1_s[1]);
         p1_cxcy_ff  <= mulf(p1_c[0], p1_c[1]);
         p1_sxsy_ff  <= mulf(p1_s[0], p1_s[1]);
         p1_sz_ff    <= p1_s[2];
         p1_cz_ff    <= p1_c[2];
         p1_pitch_ff <= sat16(resc(64'(p1_src.ln[0].z), FRAC_BITS, Q_ANGLE));
         p1_yaw_ff   <= sat16(resc(64'(p1_src.ln[1].z), FRAC_BITS, Q_ANGLE));
         p1_roll_ff  <= sat16(resc(64'(p1_src.ln[2].z), FRAC_BITS, Q_ANGLE));
      end
   end

   // back stage 2: triple products
   cmd_type              p2_cmd_ff;
   logic signed [SW-1:0] p2_t0_ff, p2_t1_ff, p2_t2_ff, p2_t3_ff;
   logic signed [SW-1:0] p2_t4_ff, p2_t5_ff, p2_t6_ff, p2_t7_ff;
   logic signed [15:0]   p2_pitch_ff, p2_yaw_ff, p2_roll_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         p2_cmd_ff   <= p1_cmd_ff;
         p2_t0_ff    <= mulf(p1_sxcy_ff, p1_cz_ff);
         p2_t1_ff    <= mulf(p1_cxsy_ff, p1_sz_ff);
         p2_t2_ff    <= mulf(p1_cxsy_ff, p1_cz_ff);
         p2_t3_ff    <= mulf(p1_sxcy_ff, p1_sz_ff);
         p2_t4_ff    <= mulf(p1_cxcy_ff, p1_sz_ff);
         p2_t5_ff    <= mulf(p1_sxsy_ff, p1_cz_ff);
         p2_t6_ff    <= mulf(p1_cxcy_ff, p1_cz_ff);
         p2_t7_ff    <= mulf(p1_sxsy_ff, p1_sz_ff);
         p2_pitch_ff <= p1_pitch_ff;
         p2_yaw_ff   <= p1_yaw_ff;
         p2_roll_ff  <= p1_roll_ff;
      end
   end

   // output register
   logic signed [15:0] out_qx_in, out_qy_in, out_qz_in, out_qw_in;
   logic signed [15:0] out_pitch_in, out_yaw_in, out_roll_in;
   logic signed [15:0] out_qx_ff, out_qy_ff, out_qz_ff, out_qw_ff;
   logic signed [15:0] out_pitch_ff, out_yaw_ff, out_roll_ff;

   always_comb begin
      if (p2_cmd_ff == CMD_Q2E) begin
         out_qx_in    = '0;
         out_qy_in    = '0;
         out_qz_in    = '0;
         out_qw_in    = '0;
         out_pitch_in = p2_pitch_ff;
         out_yaw_in   = p2_yaw_ff;
         out_roll_in  = p2_roll_ff;
      end else begin
         out_qx_in = sat16(resc(64'(p2_t0_ff) - 64'(p2_t1_ff), FRAC_BITS, Q_QUAT));
         out_qy_in = sat16(resc(64'(p2_t2_ff) + 64'(p2_t3_ff), FRAC_BITS, Q_QUAT));
         out_qz_in = sat16(resc(64'(p2_t4_ff) - 64'(p2_t5_ff), FRAC_BITS, Q_QUAT));
         out_qw_in = sat16(resc(64'(p2_t6_ff) + 64'(p2_t7_ff), FRAC_BITS, Q_QUAT));
         out_pitch_in = '0;
         out_yaw_in   = '0;
         out_roll_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         out_qx_ff    <= out_qx_in;
         out_qy_ff    <= out_qy_in;
         out_qz_ff    <= out_qz_in;
         out_qw_ff    <= out_qw_in;
         out_pitch_ff <= out_pitch_in;
         out_yaw_ff   <= out_yaw_in;
         out_roll_ff  <= out_roll_in;
      end
   end

   assign rsp_quat_x_out = out_qx_ff;
   assign rsp_quat_y_out = out_qy_ff;
   assign rsp_quat_z_out = out_qz_ff;
   assign rsp_quat_w_out = out_qw_ff;
   assign rsp_pitch_out  = out_pitch_ff;
   assign rsp_yaw_out    = out_yaw_ff;
   assign rsp_roll_out   = out_roll_ff;

endmodule
`default_nettype wire
